@@ sv/cle_pkg.sv @@
// Package for the console line editor: item structs and key/command codes.
// Used by console_line_editor and the testbench (cle_ram does not use it); depends on nothing.
`default_nettype none
package cle_pkg;

  typedef struct packed {
    logic       command;
    logic [8:0] key_code;
    logic       first_of_read;
  } cle_in_t;

  typedef struct packed {
    logic       echo_valid;
    logic [8:0] echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       dump_request;
    logic       menu_is_open;
    logic [1:0] menu_color;
    logic       read_valid;
    logic [7:0] read_char;
    logic       end_of_file;
  } cle_out_t;

  localparam logic       CMD_KEY  = 1'b0;
  localparam logic       CMD_READ = 1'b1;

  localparam logic [8:0] KEY_NUL  = 9'd0;
  localparam logic [8:0] KEY_EOT  = 9'd4;
  localparam logic [8:0] KEY_BS   = 9'd8;
  localparam logic [8:0] KEY_LF   = 9'd10;
  localparam logic [8:0] KEY_CR   = 9'd13;
  localparam logic [8:0] KEY_DUMP = 9'd16;
  localparam logic [8:0] KEY_KILL = 9'd21;
  localparam logic [8:0] KEY_S    = 9'd115;
  localparam logic [8:0] KEY_W    = 9'd119;
  localparam logic [8:0] KEY_DEL  = 9'd127;
  localparam logic [8:0] KEY_MENU = 9'd257;

  localparam logic [7:0] CHR_EOT  = 8'd4;
  localparam logic [7:0] CHR_LF   = 8'd10;

  localparam logic [7:0] ERASE_MAX = 8'd255;
  localparam logic [1:0] COLOR_MAX = 2'd3;
  localparam logic [1:0] COLOR_MIN = 2'd0;

endpackage
`default_nettype wire

@@ sv/cle_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/console_line_editor.sv @@
// Cooked-mode console line editor: line ring in cle_ram, indices and menu in flops.
// Depends on cle_pkg and cle_ram. The receiver cannot stall.
// The result strobe is registered: it comes in the cycle after accept for keys other
// than Ctrl-U and for a read with nothing committed. A read that finds a character
// passes through S_RD_WAIT for the registered RAM read data. Ctrl-U, until it stops at
// the committed text or a line feed, alternates S_KILL_RD and S_KILL_CHK for each
// character. busy is low again with the strobe. Reset (synchronous, active low) clears
// all indices, closes the menu and sets the color to 3; the line store is not cleared.
`default_nettype none
module console_line_editor #(
  parameter int LINE_DEPTH = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire cle_pkg::cle_in_t in_item,
  output logic                  busy,
  output logic                  out_valid,
  output cle_pkg::cle_out_t     out_item
);

  import cle_pkg::*;

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int IW = AW + 1;
  localparam logic [IW-1:0] DEPTH_I = IW'(LINE_DEPTH);
  localparam logic [IW-1:0] LAST_I  = IW'(2 * LINE_DEPTH - 1);
  localparam logic [IW:0]   TWO_D   = (IW + 1)'(2 * LINE_DEPTH);
  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(LINE_DEPTH);
  localparam logic [IW:0]   NEAR_W  = (IW + 1)'(LINE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_KILL_RD,
    S_KILL_CHK
  } state_t;

  state_t         state_r, state_nxt;
  logic [IW-1:0]  read_r, read_nxt;
  logic [IW-1:0]  commit_r, commit_nxt;
  logic [IW-1:0]  edit_r, edit_nxt;
  logic           menu_r, menu_nxt;
  logic [1:0]     color_r, color_nxt;
  logic [7:0]     erase_r, erase_nxt;
  logic           first_r, first_nxt;
  logic           out_valid_r, out_valid_nxt;
  cle_out_t       out_r, out_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  logic [IW:0]    fill;
  logic [IW-1:0]  edit_inc;
  logic [IW-1:0]  edit_dec;
  logic [8:0]     store_char;
  cle_out_t       res;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == LAST_I) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == '0) ? LAST_I : i - 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [IW-1:0] i);
    logic [IW-1:0] s;
    s = (i >= DEPTH_I) ? i - DEPTH_I : i;
    return s[AW-1:0];
  endfunction

  cle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fill = {1'b0, edit_r} + ((edit_r < read_r) ? TWO_D : '0) - {1'b0, read_r};
  assign edit_inc = idx_inc(edit_r);
  assign edit_dec = idx_dec(edit_r);
  assign store_char = (in_item.key_code == KEY_CR) ? KEY_LF : in_item.key_code;

  always_comb begin
    state_nxt     = state_r;
    read_nxt      = read_r;
    commit_nxt    = commit_r;
    edit_nxt      = edit_r;
    menu_nxt      = menu_r;
    color_nxt     = color_r;
    erase_nxt     = erase_r;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    res           = '0;
    ram_we        = 1'b0;
    ram_waddr     = slot_of(edit_r);
    ram_wdata     = store_char[7:0];
    ram_raddr     = slot_of(read_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          first_nxt = in_item.first_of_read;
          erase_nxt = '0;
          if (in_item.command == CMD_READ) begin
            if (read_r != commit_r) begin
              state_nxt = S_RD_WAIT;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else if (in_item.key_code == KEY_DUMP) begin
            res.dump_request = 1'b1;
            out_valid_nxt    = 1'b1;
          end else if (in_item.key_code == KEY_KILL) begin
            state_nxt = S_KILL_RD;
          end else if (in_item.key_code == KEY_BS || in_item.key_code == KEY_DEL) begin
            if (edit_r != commit_r) begin
              edit_nxt        = edit_dec;
              res.erase_count = menu_r ? 8'd0 : 8'd1;
            end
            out_valid_nxt = 1'b1;
          end else if (in_item.key_code == KEY_MENU) begin
            res.echo_valid = 1'b1;
            res.echo_char  = KEY_MENU;
            menu_nxt       = ~menu_r;
            out_valid_nxt  = 1'b1;
          end else if (in_item.key_code == KEY_W && menu_r) begin
            res.echo_valid = 1'b1;
            res.echo_char  = KEY_W;
            if (color_r != COLOR_MAX) begin
              color_nxt = color_r + 2'd1;
            end
            out_valid_nxt = 1'b1;
          end else if (in_item.key_code == KEY_S && menu_r) begin
            res.echo_valid = 1'b1;
            res.echo_char  = KEY_S;
            if (color_r != COLOR_MIN) begin
              color_nxt = color_r - 2'd1;
            end
            out_valid_nxt = 1'b1;
          end else begin
            if (!menu_r && in_item.key_code != KEY_NUL && fill < DEPTH_W) begin
              ram_we         = 1'b1;
              edit_nxt       = edit_inc;
              res.echo_valid = 1'b1;
              res.echo_char  = store_char;
              if (store_char == KEY_LF || store_char == KEY_EOT || fill == NEAR_W) begin
                commit_nxt     = edit_inc;
                res.line_ready = 1'b1;
              end
            end
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_RD_WAIT: begin
        res.read_valid = 1'b1;
        res.read_char  = ram_rdata;
        if (ram_rdata == CHR_EOT) begin
          res.end_of_file = 1'b1;
          if (first_r) begin
            read_nxt = idx_inc(read_r);
          end
        end else begin
          read_nxt = idx_inc(read_r);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_KILL_RD: begin
        ram_raddr = slot_of(edit_dec);
        if (edit_r == commit_r) begin
          res.erase_count = erase_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_KILL_CHK;
        end
      end
      S_KILL_CHK: begin
        if (ram_rdata != CHR_LF) begin
          edit_nxt = edit_dec;
          if (!menu_r && erase_r != ERASE_MAX) begin
            erase_nxt = erase_r + 8'd1;
          end
          state_nxt = S_KILL_RD;
        end else begin
          res.erase_count = erase_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.menu_is_open = menu_nxt;
    res.menu_color   = color_nxt;
    out_nxt          = out_valid_nxt ? res : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      read_r      <= '0;
      commit_r    <= '0;
      edit_r      <= '0;
      menu_r      <= 1'b0;
      color_r     <= COLOR_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      read_r      <= read_nxt;
      commit_r    <= commit_nxt;
      edit_r      <= edit_nxt;
      menu_r      <= menu_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
    erase_r <= erase_nxt;
    first_r <= first_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

@@ tb/cle_checker.sv @@
// Checker for the console line editor: watches the item and result channels,
// predicts each response from its own copy of the line ring, and compares.
// Depends on cle_pkg; hands its mismatch count and outstanding count to the top.
module cle_checker #(
  parameter int DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  cle_pkg::cle_in_t in_item,
  input  logic             out_valid,
  input  cle_pkg::cle_out_t out_item,
  output int               fails,
  output int               waiting
);
  import cle_pkg::*;

  localparam int PW = $clog2(2 * DEPTH);

  logic [7:0]    ring [DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] cm_ptr;
  logic [PW-1:0] ed_ptr;
  logic          menu_open;
  logic [1:0]    color;
  cle_out_t      awaited_responses [$];
  cle_out_t      want;
  int            n_fail = 0;

  assign fails = n_fail;

  task automatic report(string what);
    if (n_fail < 40) begin
      $display("[%0t] console_line_editor mismatch: %s", $time, what);
    end
    n_fail++;
  endtask

  task automatic check_field(string name, logic [8:0] got, logic [8:0] exp_val);
    if (got !== exp_val) begin
      report($sformatf("%s is %0d, predicted %0d", name, got, exp_val));
    end
  endtask

  function automatic cle_out_t edit_line(cle_in_t it);
    cle_out_t      r;
    logic [8:0]    c;
    logic [PW-1:0] prev;
    logic [PW-1:0] fill;
    logic          to_store;
    r = '0;
    to_store = 1'b0;
    if (it.command == CMD_KEY) begin
      if (it.key_code == KEY_DUMP) begin
        r.dump_request = 1'b1;
      end else if (it.key_code == KEY_KILL) begin
        prev = ed_ptr - 1'b1;
        while (ed_ptr != cm_ptr && ring[prev[PW-2:0]] != CHR_LF) begin
          ed_ptr = prev;
          prev = ed_ptr - 1'b1;
          if (!menu_open && r.erase_count != ERASE_MAX) begin
            r.erase_count++;
          end
        end
      end else if (it.key_code == KEY_BS || it.key_code == KEY_DEL) begin
        if (ed_ptr != cm_ptr) begin
          ed_ptr = ed_ptr - 1'b1;
          if (!menu_open) begin
            r.erase_count = 8'd1;
          end
        end
      end else if (it.key_code == KEY_MENU) begin
        r.echo_valid = 1'b1;
        r.echo_char = KEY_MENU;
        menu_open = !menu_open;
      end else if (it.key_code == KEY_W && menu_open) begin
        r.echo_valid = 1'b1;
        r.echo_char = KEY_W;
        if (color != COLOR_MAX) begin
          color++;
        end
      end else if (it.key_code == KEY_S && menu_open) begin
        r.echo_valid = 1'b1;
        r.echo_char = KEY_S;
        if (color != COLOR_MIN) begin
          color--;
        end
      end else begin
        to_store = 1'b1;
      end
      fill = ed_ptr - rd_ptr;
      if (to_store && !menu_open && it.key_code != KEY_NUL && fill < PW'(DEPTH)) begin
        c = (it.key_code == KEY_CR) ? KEY_LF : it.key_code;
        ring[ed_ptr[PW-2:0]] = c[7:0];
        ed_ptr = ed_ptr + 1'b1;
        r.echo_valid = 1'b1;
        r.echo_char = c;
        if (c == KEY_LF || c == KEY_EOT || ed_ptr == PW'(rd_ptr + DEPTH)) begin
          cm_ptr = ed_ptr;
          r.line_ready = 1'b1;
        end
      end
    end else if (rd_ptr != cm_ptr) begin
      r.read_valid = 1'b1;
      r.read_char = ring[rd_ptr[PW-2:0]];
      if (r.read_char == CHR_EOT) begin
        r.end_of_file = 1'b1;
        if (it.first_of_read) begin
          rd_ptr = rd_ptr + 1'b1;
        end
      end else begin
        rd_ptr = rd_ptr + 1'b1;
      end
    end
    r.menu_is_open = menu_open;
    r.menu_color = color;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_responses.delete();
      rd_ptr = '0;
      cm_ptr = '0;
      ed_ptr = '0;
      menu_open = 1'b0;
      color = COLOR_MAX;
      waiting <= 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (awaited_responses.size() == 0) begin
          report("result strobe with no item outstanding");
        end else begin
          want = awaited_responses.pop_front();
          check_field("echo_valid", 9'(out_item.echo_valid), 9'(want.echo_valid));
          check_field("echo_char", out_item.echo_char, want.echo_char);
          check_field("erase_count", 9'(out_item.erase_count), 9'(want.erase_count));
          check_field("line_ready", 9'(out_item.line_ready), 9'(want.line_ready));
          check_field("dump_request", 9'(out_item.dump_request), 9'(want.dump_request));
          check_field("menu_is_open", 9'(out_item.menu_is_open), 9'(want.menu_is_open));
          check_field("menu_color", 9'(out_item.menu_color), 9'(want.menu_color));
          check_field("read_valid", 9'(out_item.read_valid), 9'(want.read_valid));
          check_field("read_char", 9'(out_item.read_char), 9'(want.read_char));
          check_field("end_of_file", 9'(out_item.end_of_file), 9'(want.end_of_file));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        awaited_responses.push_back(edit_line(in_item));
      end
      waiting <= awaited_responses.size();
    end
  end

endmodule

@@ tb/console_line_editor_test.sv @@
// Top of the console line editor testbench: clock, reset, directed and random
// key and read traffic, and the verdict. Depends on cle_pkg, cle_checker and the block.
module console_line_editor_test;
  import cle_pkg::*;

  localparam int ITEM_COUNT = 1800;
  localparam int CALM_TAIL  = 200;
  localparam int LIMIT      = 3000000;

  logic     clk;
  logic     rst_n;
  logic     start;
  cle_in_t  in_item;
  logic     busy;
  logic     out_valid;
  cle_out_t out_item;
  int       fails;
  int       waiting;
  int       cycles = 0;
  int       sent = 0;
  logic     idle_on = 1'b0;

  console_line_editor DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  cle_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .fails    (fails),
    .waiting  (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("console_line_editor verification failed");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [8:0] key, logic first);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{command: cmd, key_code: key, first_of_read: first};
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
  endtask

  task automatic press(logic [8:0] key);
    send_item(CMD_KEY, key, 1'($urandom_range(0, 1)));
  endtask

  task automatic consume(logic first);
    send_item(CMD_READ, 9'($urandom), first);
  endtask

  // Holds the sender off until every response has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  task automatic type_line();
    int len;
    int pick;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 14);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) press(KEY_BS);
      else if (pick < 6) press(KEY_DEL);
      else if (pick < 9) press(KEY_KILL);
      else if (pick < 11) press(9'($urandom_range(256, 511)));
      else press(9'($urandom_range(32, 126)));
    end
    case ($urandom_range(0, 4))
      0, 1: press(KEY_LF);
      2: press(KEY_CR);
      3: press(KEY_EOT);
      default: ;
    endcase
  endtask

  task automatic read_call();
    int n;
    n = $urandom_range(1, 24);
    consume(1'b1);
    repeat (n - 1) consume(1'b0);
  endtask

  task automatic menu_session();
    press(KEY_MENU);
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 5))
        0, 1: press(KEY_W);
        2, 3: press(KEY_S);
        4: press(9'($urandom_range(32, 126)));
        default: press($urandom_range(0, 1) ? KEY_BS : KEY_KILL);
      endcase
    end
    press(KEY_MENU);
  endtask

  task automatic control_key();
    case ($urandom_range(0, 7))
      0: press(KEY_DUMP);
      1: press(KEY_KILL);
      2: press(KEY_BS);
      3: press(KEY_DEL);
      4: press(KEY_NUL);
      5: press(KEY_CR);
      6: press(KEY_LF);
      default: press(KEY_EOT);
    endcase
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    press(KEY_NUL);
    press(9'd97);
    press(9'd511);
    press(KEY_BS);
    press(KEY_DEL);
    press(9'd98);
    press(KEY_KILL);
    press(KEY_CR);
    press(KEY_DUMP);
    press(9'd120);
    press(KEY_EOT);
    consume(1'b1);
    consume(1'b0);
    consume(1'b0);
    consume(1'b1);
    consume(1'b1);
    press(9'd122);
    press(KEY_MENU);
    press(KEY_W);
    repeat (4) press(KEY_S);
    press(9'd113);
    press(KEY_BS);
    press(KEY_MENU);
    drain();

    while (sent < ITEM_COUNT) begin
      idle_on = (sent < ITEM_COUNT - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: type_line();
        4, 5, 6: read_call();
        7: menu_session();
        8: send_item(1'($urandom), 9'($urandom), 1'($urandom));
        default: control_key();
      endcase
      if ($urandom_range(0, 39) == 0) begin
        drain();
      end
    end

    start <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("console_line_editor verification clean");
    end else begin
      $display("console_line_editor verification failed");
    end
    $finish;
  end

endmodule

@@ console_line_editor.f @@
sv/cle_pkg.sv
sv/cle_ram.sv
sv/console_line_editor.sv
tb/cle_checker.sv
tb/console_line_editor_test.sv
